FILE: hdl/hss_pkg.sv
`timescale 1ns / 1ps

package hss_pkg;

    localparam int COORD_W    = 32;
    localparam int POS_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int H_W        = 20;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TENSION    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS       = 2'd2;

    // Request codes
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam logic signed [15:0] Q14_ONE     = 16'sd16384;
    localparam logic signed [15:0] Q14_NEG_ONE = -16'sd16384;

    typedef struct packed {
        logic adv;
        logic wr_en;
    } lane_ctl_t;

    typedef struct packed {
        logic signed [H_W-1:0] h0;
        logic signed [H_W-1:0] h1;
        logic signed [H_W-1:0] h2;
        logic signed [H_W-1:0] h3;
    } basis_t;

endpackage

FILE: hdl/hss_if.sv
`timescale 1ns / 1ps

interface hss_in_if;
    import hss_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [7:0]                point_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [POS_W-1:0]          curve_position;

    modport source (output valid, req_type, point_index, coord_x, coord_y, coord_z,
                    curve_position, input ready);
    modport sink (input valid, req_type, point_index, coord_x, coord_y, coord_z,
                  curve_position, output ready);
endinterface

interface hss_out_if;
    import hss_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] sample_x;
    logic signed [COORD_W-1:0] sample_y;
    logic signed [COORD_W-1:0] sample_z;

    modport source (output valid, sample_x, sample_y, sample_z, input ready);
    modport sink (input valid, sample_x, sample_y, sample_z, output ready);
endinterface

interface hss_cfg_if;
    import hss_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/hermite_spline_sampler_top.sv
`timescale 1ns / 1ps

// Channel   Role    Payload
// cfg       sink    index, data (num_points, tension, bias)
// req_ch    sink    req_type, point_index, coord_x/y/z, curve_position
// rsp_ch    source  sample_x, sample_y, sample_z
//
// One item is taken per cycle while rsp_ch does not stall. A sample transfer passes
// through a pipeline of seven stages (index split, table read, basis, tangent
// multiply, tangent round, blend multiply, sum and saturate) on its way to rsp_ch.
// Load items write the table at stage one and produce no transfer.
// rst_n clears only the control state; the table is undefined until loaded.
// When rsp_ch stalls the whole pipeline holds and req_ch drops ready.
module hermite_spline_sampler_top #(
    parameter int MAX_POINTS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    hss_cfg_if.sink     cfg,
    hss_in_if.sink      req_ch,
    hss_out_if.source   rsp_ch
);
    import hss_pkg::*;

    localparam int AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

    // Configuration registers
    logic [8:0]         num_points_reg;
    logic signed [15:0] tension_reg;
    logic signed [15:0] bias_reg;

    // Tangent weights, refreshed from the registers every cycle
    logic [15:0] a_reg, b_reg;

    // Pipeline valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic adv;

    // Stage one payload
    logic                      req1_reg;
    logic [7:0]                pidx1_reg;
    logic                      ldok1_reg;
    logic signed [COORD_W-1:0] cx1_reg, cy1_reg, cz1_reg;
    logic [25:0]               pos1_reg;
    logic [8:0]                last1_reg;

    // Basis path
    logic [15:0] w2_reg, t2_2_reg, w3_reg, t2_3_reg, t3_3_reg;
    basis_t      h4_reg, h5_reg;
    basis_t      h_next;

    logic [8:0]         n_c, nm1;
    logic [POS_W-1:0]   t_c;
    logic [25:0]        pos_next;
    logic signed [15:0] ten_c, bias_c;
    logic signed [16:0] one_p_bias, one_m_bias, one_m_ten;
    logic [31:0]        prod_a, prod_b;

    logic [9:0]    seg, last10, i0, i1, i2, i3;
    logic [15:0]   w;
    logic [15:0]   t2_next, t3_next;
    lane_ctl_t     ctl;
    logic [AW-1:0] waddr;

    logic signed [19:0] t2s, t3s, ws;

    logic signed [COORD_W-1:0] res_x, res_y, res_z;

    // Config writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg <= 9'd2;
            tension_reg    <= '0;
            bias_reg       <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_NUM_POINTS: num_points_reg <= cfg.data[8:0];
                CFG_TENSION:    tension_reg    <= $signed(cfg.data);
                CFG_BIAS:       bias_reg       <= $signed(cfg.data);
                default:        ;
            endcase
        end
    end

    // Clamp tension and bias to +-1.0 and form a = (1+bias)(1-tension)/2,
    // b = (1-bias)(1-tension)/2 in Q14
    always_comb
    begin
        if (tension_reg > Q14_ONE)
            ten_c = Q14_ONE;
        else if (tension_reg < Q14_NEG_ONE)
            ten_c = Q14_NEG_ONE;
        else
            ten_c = tension_reg;
        if (bias_reg > Q14_ONE)
            bias_c = Q14_ONE;
        else if (bias_reg < Q14_NEG_ONE)
            bias_c = Q14_NEG_ONE;
        else
            bias_c = bias_reg;
    end

    assign one_p_bias = 17'sd16384 + 17'(bias_c);
    assign one_m_bias = 17'sd16384 - 17'(bias_c);
    assign one_m_ten  = 17'sd16384 - 17'(ten_c);
    assign prod_a     = 32'(one_p_bias[15:0]) * 32'(one_m_ten[15:0]);
    assign prod_b     = 32'(one_m_bias[15:0]) * 32'(one_m_ten[15:0]);

    always_ff @(posedge clk)
    begin
        a_reg <= 16'((prod_a + 32'd16384) >> 15);
        b_reg <= 16'((prod_b + 32'd16384) >> 15);
    end

    // Advance the whole pipeline unless the output register is stuck
    assign adv          = !v7_reg || rsp_ch.ready;
    assign req_ch.ready = adv;

    // Segment count and position clamps
    always_comb
    begin
        if (num_points_reg < 9'd2)
            n_c = 9'd2;
        else if (32'(num_points_reg) > 32'(MAX_POINTS))
            n_c = 9'(MAX_POINTS);
        else
            n_c = num_points_reg;
        if (req_ch.curve_position > 17'd65536)
            t_c = 17'd65536;
        else
            t_c = req_ch.curve_position;
    end

    assign nm1      = n_c - 9'd1;
    assign pos_next = {17'b0, nm1} * {9'b0, t_c};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= req_ch.valid;
            v2_reg <= v1_reg && (req1_reg == REQ_SAMPLE);
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            req1_reg  <= req_ch.req_type;
            pidx1_reg <= req_ch.point_index;
            ldok1_reg <= 32'(req_ch.point_index) < 32'(MAX_POINTS);
            cx1_reg   <= req_ch.coord_x;
            cy1_reg   <= req_ch.coord_y;
            cz1_reg   <= req_ch.coord_z;
            pos1_reg  <= pos_next;
            last1_reg <= nm1;
        end
    end

    // Split position into segment and weight; clamp the four neighbors
    assign seg    = pos1_reg[25:16];
    assign w      = pos1_reg[15:0];
    assign last10 = {1'b0, last1_reg};
    assign i0     = (seg == 10'd0) ? 10'd0 : seg - 10'd1;
    assign i1     = (seg > last10) ? last10 : seg;
    assign i2     = (seg + 10'd1 > last10) ? last10 : seg + 10'd1;
    assign i3     = (seg + 10'd2 > last10) ? last10 : seg + 10'd2;

    assign ctl.adv   = adv;
    assign ctl.wr_en = adv && v1_reg && (req1_reg == REQ_LOAD) && ldok1_reg;
    assign waddr     = AW'(pidx1_reg);

    assign t2_next = 16'((32'(w) * 32'(w) + 32'd32768) >> 16);
    assign t3_next = 16'((32'(t2_2_reg) * 32'(w2_reg) + 32'd32768) >> 16);

    // Hermite basis in Q16
    assign t2s = $signed({4'b0, t2_3_reg});
    assign t3s = $signed({4'b0, t3_3_reg});
    assign ws  = $signed({4'b0, w3_reg});

    always_comb
    begin
        h_next.h0 = 20'sd65536 + 20'sd2 * t3s - 20'sd3 * t2s;
        h_next.h1 = t3s - 20'sd2 * t2s + ws;
        h_next.h2 = t3s - t2s;
        h_next.h3 = 20'sd3 * t2s - 20'sd2 * t3s;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w2_reg   <= w;
            t2_2_reg <= t2_next;
            w3_reg   <= w2_reg;
            t2_3_reg <= t2_2_reg;
            t3_3_reg <= t3_next;
            h4_reg   <= h_next;
            h5_reg   <= h4_reg;
        end
    end

    // One lane per coordinate
    hss_lane #(.MAX_POINTS(MAX_POINTS), .AW(AW)) lane_x (
        .clk    (clk),
        .ctl    (ctl),
        .waddr  (waddr),
        .wdata  (cx1_reg),
        .raddr0 (AW'(i0)),
        .raddr1 (AW'(i1)),
        .raddr2 (AW'(i2)),
        .raddr3 (AW'(i3)),
        .coef_a (a_reg),
        .coef_b (b_reg),
        .basis  (h5_reg),
        .result (res_x)
    );

    hss_lane #(.MAX_POINTS(MAX_POINTS), .AW(AW)) lane_y (
        .clk    (clk),
        .ctl    (ctl),
        .waddr  (waddr),
        .wdata  (cy1_reg),
        .raddr0 (AW'(i0)),
        .raddr1 (AW'(i1)),
        .raddr2 (AW'(i2)),
        .raddr3 (AW'(i3)),
        .coef_a (a_reg),
        .coef_b (b_reg),
        .basis  (h5_reg),
        .result (res_y)
    );

    hss_lane #(.MAX_POINTS(MAX_POINTS), .AW(AW)) lane_z (
        .clk    (clk),
        .ctl    (ctl),
        .waddr  (waddr),
        .wdata  (cz1_reg),
        .raddr0 (AW'(i0)),
        .raddr1 (AW'(i1)),
        .raddr2 (AW'(i2)),
        .raddr3 (AW'(i3)),
        .coef_a (a_reg),
        .coef_b (b_reg),
        .basis  (h5_reg),
        .result (res_z)
    );

    // Merge the lane results into one transfer
    assign rsp_ch.valid    = v7_reg;
    assign rsp_ch.sample_x = res_x;
    assign rsp_ch.sample_y = res_y;
    assign rsp_ch.sample_z = res_z;

endmodule

FILE: hdl/hss_lane.sv
`timescale 1ns / 1ps

module hss_lane #(
    parameter int MAX_POINTS = 256,
    parameter int AW         = 8
) (
    input  logic                              clk,
    input  hss_pkg::lane_ctl_t                ctl,
    input  logic [AW-1:0]                     waddr,
    input  logic signed [hss_pkg::COORD_W-1:0] wdata,
    input  logic [AW-1:0]                     raddr0,
    input  logic [AW-1:0]                     raddr1,
    input  logic [AW-1:0]                     raddr2,
    input  logic [AW-1:0]                     raddr3,
    input  logic [15:0]                       coef_a,
    input  logic [15:0]                       coef_b,
    input  hss_pkg::basis_t                   basis,
    output logic signed [hss_pkg::COORD_W-1:0] result
);
    import hss_pkg::*;

    // Two copies so that four neighbors come out per cycle while ctl.adv is set
    logic signed [COORD_W-1:0] mem_a [MAX_POINTS];
    logic signed [COORD_W-1:0] mem_b [MAX_POINTS];

    logic signed [31:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [32:0] d0_reg, d1_reg, d2_reg;
    logic signed [31:0] p1_3_reg, p2_3_reg, p1_4_reg, p2_4_reg, p1_5_reg, p2_5_reg;
    logic signed [49:0] pa0_reg, pb1_reg, pa1_reg, pb2_reg;
    logic signed [36:0] m0_reg, m1_reg;
    logic signed [56:0] q0_reg, q1_reg, q2_reg, q3_reg;
    logic signed [31:0] res_reg;

    logic signed [16:0] sa, sb;
    logic signed [50:0] m0_sum, m1_sum;
    logic signed [58:0] acc_next;
    logic signed [42:0] rnd_next;
    logic signed [31:0] res_next;

    assign sa = $signed({1'b0, coef_a});
    assign sb = $signed({1'b0, coef_b});

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem_a[waddr] <= wdata;
        end
        if (ctl.adv)
        begin
            p0_reg <= mem_a[raddr0];
            p1_reg <= mem_a[raddr1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem_b[waddr] <= wdata;
        end
        if (ctl.adv)
        begin
            p2_reg <= mem_b[raddr2];
            p3_reg <= mem_b[raddr3];
        end
    end

    assign m0_sum   = 51'(pa0_reg) + 51'(pb1_reg) + 51'sd8192;
    assign m1_sum   = 51'(pa1_reg) + 51'(pb2_reg) + 51'sd8192;
    assign acc_next = 59'(q0_reg) + 59'(q1_reg) + 59'(q2_reg) + 59'(q3_reg) + 59'sd32768;
    assign rnd_next = 43'(acc_next >>> 16);

    always_comb
    begin
        if (rnd_next > 43'sd2147483647)
            res_next = 32'sh7FFFFFFF;
        else if (rnd_next < -43'sd2147483648)
            res_next = 32'sh80000000;
        else
            res_next = 32'(rnd_next);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            // differences
            d0_reg   <= 33'(p1_reg) - 33'(p0_reg);
            d1_reg   <= 33'(p2_reg) - 33'(p1_reg);
            d2_reg   <= 33'(p3_reg) - 33'(p2_reg);
            p1_3_reg <= p1_reg;
            p2_3_reg <= p2_reg;
            // tangent products
            pa0_reg  <= 50'(d0_reg) * 50'(sa);
            pb1_reg  <= 50'(d1_reg) * 50'(sb);
            pa1_reg  <= 50'(d1_reg) * 50'(sa);
            pb2_reg  <= 50'(d2_reg) * 50'(sb);
            p1_4_reg <= p1_3_reg;
            p2_4_reg <= p2_3_reg;
            // tangents
            m0_reg   <= 37'(m0_sum >>> 14);
            m1_reg   <= 37'(m1_sum >>> 14);
            p1_5_reg <= p1_4_reg;
            p2_5_reg <= p2_4_reg;
            // basis products
            q0_reg   <= 57'(basis.h0) * 57'(p1_5_reg);
            q1_reg   <= 57'(basis.h1) * 57'(m0_reg);
            q2_reg   <= 57'(basis.h2) * 57'(m1_reg);
            q3_reg   <= 57'(basis.h3) * 57'(p2_5_reg);
            res_reg  <= res_next;
        end
    end

    assign result = res_reg;

endmodule
